// ----- rtl/pfea_pkg.sv -----
// shared types, constants and saturating arithmetic helpers for the pid controller
package pfea_pkg;

   localparam int unsigned DW          = 32;           // data word width
   localparam int unsigned FB          = 16;           // fraction bits of gains and steps
   localparam int unsigned SMOOTH_BITS = 16;           // fraction bits of the smoothing weight
   localparam int unsigned STEP_W      = DW - 1;       // unsigned time step width
   localparam int unsigned OPW         = DW + 1;       // multiplier operand width
   localparam int unsigned PW          = 2 * OPW;      // full product width
   localparam int unsigned CSR_IDX_W   = 3;

   localparam logic [SMOOTH_BITS:0] SMOOTH_ONE = {1'b1, {SMOOTH_BITS{1'b0}}};
   localparam logic [STEP_W-1:0]    STEP_ONE   = {{(STEP_W-FB-1){1'b0}}, 1'b1, {FB{1'b0}}};

   localparam logic signed [DW-1:0] SMAX = {1'b0, {(DW-1){1'b1}}};
   localparam logic signed [DW-1:0] SMIN = {1'b1, {(DW-1){1'b0}}};
   localparam logic signed [PW-1:0] PMAX = {{(PW-DW+1){1'b0}}, {(DW-1){1'b1}}};
   localparam logic signed [PW-1:0] PMIN = {{(PW-DW+1){1'b1}}, {(DW-1){1'b0}}};

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_GAIN_P       = 3'd0,
      CSR_GAIN_I       = 3'd1,
      CSR_GAIN_D       = 3'd2,
      CSR_TIME_STEP    = 3'd3,
      CSR_INV_STEP     = 3'd4,
      CSR_OUTPUT_LOW   = 3'd5,
      CSR_OUTPUT_HIGH  = 3'd6,
      CSR_SMOOTHING    = 3'd7
   } csr_index_type;

   localparam logic MODE_UPDATE = 1'b0;
   localparam logic MODE_CLEAR  = 1'b1;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MUL_A,
      ST_MUL_B,
      ST_FILT,
      ST_MUL_I,
      ST_MUL_D,
      ST_MUL_P,
      ST_MUL_G,
      ST_MUL_K,
      ST_FINISH
   } state_type;

   // floor shift of a full product, saturated to the data word
   function automatic logic signed [DW-1:0] sat_prod(input logic signed [PW-1:0] p,
                                                      input int unsigned sh);
      logic signed [PW-1:0] q;
      q = p >>> sh;
      if (q > PMAX) begin
         sat_prod = SMAX;
      end else if (q < PMIN) begin
         sat_prod = SMIN;
      end else begin
         sat_prod = q[DW-1:0];
      end
   endfunction

   function automatic logic signed [DW-1:0] add_sat(input logic signed [DW-1:0] a,
                                                     input logic signed [DW-1:0] b);
      logic signed [DW:0] s;
      s = {a[DW-1], a} + {b[DW-1], b};
      if (s[DW] != s[DW-1]) begin
         add_sat = s[DW] ? SMIN : SMAX;
      end else begin
         add_sat = s[DW-1:0];
      end
   endfunction

   function automatic logic signed [DW-1:0] sub_sat(input logic signed [DW-1:0] a,
                                                     input logic signed [DW-1:0] b);
      logic signed [DW:0] s;
      s = {a[DW-1], a} - {b[DW-1], b};
      if (s[DW] != s[DW-1]) begin
         sub_sat = s[DW] ? SMIN : SMAX;
      end else begin
         sub_sat = s[DW-1:0];
      end
   endfunction

   // upper limit is tested first: with inverted limits, values above it give the upper limit and all others the lower
   function automatic logic signed [DW-1:0] clamp(input logic signed [DW-1:0] v,
                                                   input logic signed [DW-1:0] lo,
                                                   input logic signed [DW-1:0] hi);
      if (v > hi) begin
         clamp = hi;
      end else if (v < lo) begin
         clamp = lo;
      end else begin
         clamp = v;
      end
   endfunction

endpackage

// ----- rtl/pfea_if.sv -----
// request and response channel interfaces of the pid controller
interface pfea_req_if;
   logic                            valid;
   logic                            ready;
   logic                            mode;
   logic signed [pfea_pkg::DW-1:0]  target;
   logic signed [pfea_pkg::DW-1:0]  measured;

   modport source (output valid, output mode, output target, output measured, input ready);
   modport sink   (input valid, input mode, input target, input measured, output ready);
endinterface

interface pfea_rsp_if;
   logic                            valid;
   logic                            ready;
   logic signed [pfea_pkg::DW-1:0]  drive;

   modport source (output valid, output drive, input ready);
   modport sink   (input valid, input drive, output ready);
endinterface

// ----- rtl/pid_filtered_error_antiwindup.sv -----
// pid controller with low-pass filtered error and clamped integral, one shared multiplier
// an update request runs after acceptance on one registered 33x33 multiplier, in order through
// mul_a, mul_b, filt (filter sum), mul_i, mul_d, mul_p, mul_g, mul_k (seven products) and finish,
// where its response is registered; a new request is taken only back in idle; finish holds while
// an older response is unread; a clear request zeroes the state and gives no response
// synchronous active-high reset: idle, no response, state zero, limits and gains zero, steps one
module pid_filtered_error_antiwindup (
   input  logic                                 clock,
   input  logic                                 reset,
   pfea_req_if.sink                             req_chan,
   pfea_rsp_if.source                           rsp_chan,
   input  logic                                 csr_write_enable,
   input  logic [pfea_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [pfea_pkg::DW-1:0]              csr_write_data
);

   localparam int unsigned DW  = pfea_pkg::DW;
   localparam int unsigned OPW = pfea_pkg::OPW;
   localparam int unsigned PW  = pfea_pkg::PW;
   localparam int unsigned SB  = pfea_pkg::SMOOTH_BITS;
   localparam int unsigned SW  = pfea_pkg::STEP_W;

   // configuration registers
   logic signed [DW-1:0] gain_p_ff, gain_i_ff, gain_d_ff;
   logic [SW-1:0]        time_step_ff, inv_step_ff;
   logic signed [DW-1:0] out_low_ff, out_high_ff;
   logic [SB:0]          smoothing_ff;

   // controller state carried from update to update
   logic signed [DW-1:0] integral_ff, integral_in;
   logic signed [DW-1:0] last_ff, last_in;

   // sequencer and working registers
   pfea_pkg::state_type  state_ff, state_in;
   logic signed [PW-1:0] prod_ff, prod_in;
   logic signed [DW-1:0] err_ff, err_in;
   logic signed [DW-1:0] acc_ff, acc_in;
   logic signed [DW-1:0] filt_ff, filt_in;
   logic signed [DW-1:0] diff_ff, diff_in;
   logic signed [DW-1:0] isum_ff, isum_in;
   logic signed [DW-1:0] deriv_ff, deriv_in;

   // response register
   logic                 rsp_valid_ff, rsp_valid_in;
   logic signed [DW-1:0] drive_ff, drive_in;

   // shared multiplier operands
   logic signed [OPW-1:0] mul_a, mul_b;
   logic signed [PW-1:0]  product;

   // smoothing weight limited to one, and its complement
   logic [SB:0]          s_eff;
   logic [SB:0]          s_comp;

   // registered product scaled both ways
   logic signed [DW-1:0] prod_smooth;
   logic signed [DW-1:0] prod_frac;

   assign s_eff       = (smoothing_ff > pfea_pkg::SMOOTH_ONE) ? pfea_pkg::SMOOTH_ONE
                                                              : smoothing_ff;
   assign s_comp      = pfea_pkg::SMOOTH_ONE - s_eff;
   assign product     = mul_a * mul_b;
   assign prod_smooth = pfea_pkg::sat_prod(prod_ff, SB);
   assign prod_frac   = pfea_pkg::sat_prod(prod_ff, pfea_pkg::FB);

   assign req_chan.ready = (state_ff == pfea_pkg::ST_IDLE);
   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.drive = drive_ff;

   // configuration writes; the user must write only while the controller is idle, the block does not enforce it
   always_ff @(posedge clock) begin
      if (reset) begin
         gain_p_ff    <= '0;
         gain_i_ff    <= '0;
         gain_d_ff    <= '0;
         time_step_ff <= pfea_pkg::STEP_ONE;
         inv_step_ff  <= pfea_pkg::STEP_ONE;
         out_low_ff   <= '0;
         out_high_ff  <= '0;
         smoothing_ff <= '0;
      end else if (csr_write_enable) begin
         unique case (pfea_pkg::csr_index_type'(csr_index))
            pfea_pkg::CSR_GAIN_P:      gain_p_ff    <= csr_write_data;
            pfea_pkg::CSR_GAIN_I:      gain_i_ff    <= csr_write_data;
            pfea_pkg::CSR_GAIN_D:      gain_d_ff    <= csr_write_data;
            pfea_pkg::CSR_TIME_STEP:   time_step_ff <= csr_write_data[SW-1:0];
            pfea_pkg::CSR_INV_STEP:    inv_step_ff  <= csr_write_data[SW-1:0];
            pfea_pkg::CSR_OUTPUT_LOW:  out_low_ff   <= csr_write_data;
            pfea_pkg::CSR_OUTPUT_HIGH: out_high_ff  <= csr_write_data;
            pfea_pkg::CSR_SMOOTHING:   smoothing_ff <= csr_write_data[SB:0];
            default: ;
         endcase
      end
   end

   // control state and the carried controller state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pfea_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
         integral_ff  <= '0;
         last_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         integral_ff  <= integral_in;
         last_ff      <= last_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      prod_ff  <= prod_in;
      err_ff   <= err_in;
      acc_ff   <= acc_in;
      filt_ff  <= filt_in;
      diff_ff  <= diff_in;
      isum_ff  <= isum_in;
      deriv_ff <= deriv_in;
      drive_ff <= drive_in;
   end

   // sequencer: the product states feed the multiplier, and the states after them fold in the previous product
   always_comb begin
      state_in     = state_ff;
      prod_in      = prod_ff;
      err_in       = err_ff;
      acc_in       = acc_ff;
      filt_in      = filt_ff;
      diff_in      = diff_ff;
      isum_in      = isum_ff;
      deriv_in     = deriv_ff;
      drive_in     = drive_ff;
      integral_in  = integral_ff;
      last_in      = last_ff;
      rsp_valid_in = rsp_valid_ff;
      mul_a        = '0;
      mul_b        = '0;

      // response taken downstream
      if (rsp_valid_ff && rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         pfea_pkg::ST_IDLE: begin
            if (req_chan.valid) begin
               if (req_chan.mode == pfea_pkg::MODE_CLEAR) begin
                  integral_in = '0;
                  last_in     = '0;
               end else begin
                  err_in   = pfea_pkg::sub_sat(req_chan.target, req_chan.measured);
                  state_in = pfea_pkg::ST_MUL_A;
               end
            end
         end
         pfea_pkg::ST_MUL_A: begin
            // weight of the previous filtered error
            mul_a    = {{(OPW-SB-1){1'b0}}, s_eff};
            mul_b    = {last_ff[DW-1], last_ff};
            prod_in  = product;
            state_in = pfea_pkg::ST_MUL_B;
         end
         pfea_pkg::ST_MUL_B: begin
            // weight of the new error
            acc_in   = prod_smooth;
            mul_a    = {{(OPW-SB-1){1'b0}}, s_comp};
            mul_b    = {err_ff[DW-1], err_ff};
            prod_in  = product;
            state_in = pfea_pkg::ST_FILT;
         end
         pfea_pkg::ST_FILT: begin
            filt_in  = pfea_pkg::add_sat(acc_ff, prod_smooth);
            state_in = pfea_pkg::ST_MUL_I;
         end
         pfea_pkg::ST_MUL_I: begin
            // integral increment, and the change of filtered error
            diff_in  = pfea_pkg::sub_sat(filt_ff, last_ff);
            mul_a    = {filt_ff[DW-1], filt_ff};
            mul_b    = {{(OPW-SW){1'b0}}, time_step_ff};
            prod_in  = product;
            state_in = pfea_pkg::ST_MUL_D;
         end
         pfea_pkg::ST_MUL_D: begin
            // anti-windup: integral held inside the output limits
            isum_in  = pfea_pkg::clamp(pfea_pkg::add_sat(integral_ff, prod_frac),
                                       out_low_ff, out_high_ff);
            mul_a    = {diff_ff[DW-1], diff_ff};
            mul_b    = {{(OPW-SW){1'b0}}, inv_step_ff};
            prod_in  = product;
            state_in = pfea_pkg::ST_MUL_P;
         end
         pfea_pkg::ST_MUL_P: begin
            deriv_in = prod_frac;
            mul_a    = {gain_p_ff[DW-1], gain_p_ff};
            mul_b    = {filt_ff[DW-1], filt_ff};
            prod_in  = product;
            state_in = pfea_pkg::ST_MUL_G;
         end
         pfea_pkg::ST_MUL_G: begin
            acc_in   = prod_frac;
            mul_a    = {gain_i_ff[DW-1], gain_i_ff};
            mul_b    = {isum_ff[DW-1], isum_ff};
            prod_in  = product;
            state_in = pfea_pkg::ST_MUL_K;
         end
         pfea_pkg::ST_MUL_K: begin
            acc_in   = pfea_pkg::add_sat(acc_ff, prod_frac);
            mul_a    = {gain_d_ff[DW-1], gain_d_ff};
            mul_b    = {deriv_ff[DW-1], deriv_ff};
            prod_in  = product;
            state_in = pfea_pkg::ST_FINISH;
         end
         pfea_pkg::ST_FINISH: begin
            // waits here only while an older response is still unread
            if (!rsp_valid_ff || rsp_chan.ready) begin
               drive_in     = pfea_pkg::clamp(pfea_pkg::add_sat(acc_ff, prod_frac),
                                              out_low_ff, out_high_ff);
               rsp_valid_in = 1'b1;
               integral_in  = isum_ff;
               last_in      = filt_ff;
               state_in     = pfea_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = pfea_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

// ----- tb/sv/tb_top.sv -----
// self-checking testbench of the pid controller with filtered error and clamped integral
module tb_top;

   localparam int unsigned CSR_IDX_W   = pfea_pkg::CSR_IDX_W;
   localparam int unsigned DW          = pfea_pkg::DW;
   localparam int unsigned FB          = pfea_pkg::FB;
   localparam int unsigned SMOOTH_BITS = pfea_pkg::SMOOTH_BITS;
   localparam int unsigned STEP_W      = pfea_pkg::STEP_W;

   logic clock;
   logic reset;
   logic                 csr_write_enable;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [DW-1:0]        csr_write_data;

   pfea_req_if req_bus ();
   pfea_rsp_if rsp_bus ();

   pid_filtered_error_antiwindup i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_chan         (req_bus),
      .rsp_chan         (rsp_bus),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   // extra cycles after the last response before the block counts as idle
   localparam int unsigned SETTLE_CYCLES = 15;
   localparam int unsigned PHASES        = 13;
   localparam int unsigned PHASE_ITEMS   = 100;

   // shadow copy of the register file, reset values
   longint kp_reg     = 0;
   longint ki_reg     = 0;
   longint kd_reg     = 0;
   longint dt_reg     = 65536;
   longint inv_dt_reg = 65536;
   longint lim_lo_reg = 0;
   longint lim_hi_reg = 0;
   longint smooth_reg = 0;

   // shadow copy of the controller state
   longint integ_state = 0;
   longint filt_state  = 0;

   logic signed [DW-1:0] expected_drive[$];
   logic signed [DW-1:0] drive_want;

   int unsigned req_idle_pct = 15;
   int unsigned rsp_idle_pct = 15;
   int unsigned fail_count    = 0;
   int unsigned checked_count = 0;
   int unsigned update_count  = 0;
   int unsigned clear_count   = 0;
   int unsigned setting_count = 0;

   // clock, period 10
   initial clock = 1'b0;
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // run limit, far above the slowest correct run
   initial begin
      #2000000;
      $display("CHECKS FAILED");
      $finish;
   end

   // ---------------------------------------------------------------------------------------
   // predictor arithmetic, all in 64-bit signed so products never overflow
   // ---------------------------------------------------------------------------------------

   // saturate to the signed data word
   function automatic longint sat_word(input longint v);
      if (v > longint'(pfea_pkg::SMAX)) begin
         return longint'(pfea_pkg::SMAX);
      end
      if (v < longint'(pfea_pkg::SMIN)) begin
         return longint'(pfea_pkg::SMIN);
      end
      return v;
   endfunction

   // exact product, floor shift, then saturate
   function automatic longint mul_shift(input longint a, input longint b, input int sh);
      longint p;
      p = a * b;
      return sat_word(p >>> sh);
   endfunction

   // upper limit is tested first: with inverted limits, values above it give it and all others the lower
   function automatic longint clamp_limits(input longint v);
      if (v > lim_hi_reg) begin
         return lim_hi_reg;
      end
      if (v < lim_lo_reg) begin
         return lim_lo_reg;
      end
      return v;
   endfunction

   // one control update: advances the shadow state and gives the expected drive
   function automatic logic signed [DW-1:0] compute_drive(input logic signed [DW-1:0] tgt,
                                                          input logic signed [DW-1:0] meas);
      longint weight;
      longint err;
      longint filt;
      longint isum;
      longint deriv;
      longint acc;
      // smoothing weight above one is taken as one
      weight = (smooth_reg > 65536) ? 65536 : smooth_reg;
      err    = sat_word(longint'(tgt) - longint'(meas));
      filt   = sat_word(mul_shift(weight, filt_state, SMOOTH_BITS) +
                        mul_shift(65536 - weight, err, SMOOTH_BITS));
      // anti-windup: the integral is held inside the output limits
      isum   = clamp_limits(sat_word(integ_state + mul_shift(filt, dt_reg, FB)));
      // derivative on the filtered error, no division
      deriv  = mul_shift(sat_word(filt - filt_state), inv_dt_reg, FB);
      acc    = sat_word(mul_shift(kp_reg, filt, FB) + mul_shift(ki_reg, isum, FB));
      acc    = sat_word(acc + mul_shift(kd_reg, deriv, FB));
      acc    = clamp_limits(acc);
      integ_state = isum;
      filt_state  = filt;
      return acc[DW-1:0];
   endfunction

   // ---------------------------------------------------------------------------------------
   // shared driving tasks
   // ---------------------------------------------------------------------------------------

   // one request: random idle, then hold valid until accepted, then predict
   task automatic send_request(input logic mode, input logic signed [DW-1:0] tgt,
                               input logic signed [DW-1:0] meas);
      @(negedge clock);
      while ($urandom_range(99) < req_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid    <= 1'b1;
      req_bus.mode     <= mode;
      req_bus.target   <= tgt;
      req_bus.measured <= meas;
      do begin
         @(posedge clock);
      end while (!req_bus.ready);
      if (mode == pfea_pkg::MODE_CLEAR) begin
         // clear gives no response
         integ_state = 0;
         filt_state  = 0;
         clear_count++;
      end else begin
         expected_drive.push_back(compute_drive(tgt, meas));
         update_count++;
      end
   endtask

   // drop valid and wait until every response is in and the block has settled
   task automatic wait_drained();
      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (expected_drive.size() != 0) begin
         @(negedge clock);
      end
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // write one register and mirror it; the enable is left high for back-to-back writes
   task automatic csr_write(input pfea_pkg::csr_index_type idx, input logic [DW-1:0] data);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= data;
      @(posedge clock);
      case (idx)
         pfea_pkg::CSR_GAIN_P:      kp_reg     = longint'($signed(data));
         pfea_pkg::CSR_GAIN_I:      ki_reg     = longint'($signed(data));
         pfea_pkg::CSR_GAIN_D:      kd_reg     = longint'($signed(data));
         pfea_pkg::CSR_TIME_STEP:   dt_reg     = longint'(data[STEP_W-1:0]);
         pfea_pkg::CSR_INV_STEP:    inv_dt_reg = longint'(data[STEP_W-1:0]);
         pfea_pkg::CSR_OUTPUT_LOW:  lim_lo_reg = longint'($signed(data));
         pfea_pkg::CSR_OUTPUT_HIGH: lim_hi_reg = longint'($signed(data));
         pfea_pkg::CSR_SMOOTHING:   smooth_reg = longint'(data[SMOOTH_BITS:0]);
         default: ;
      endcase
   endtask

   // full register set, only ever written with the block idle
   task automatic apply_settings(input logic [DW-1:0] kp, input logic [DW-1:0] ki,
                                 input logic [DW-1:0] kd, input logic [DW-1:0] dt,
                                 input logic [DW-1:0] inv_dt, input logic [DW-1:0] lo,
                                 input logic [DW-1:0] hi, input logic [DW-1:0] sm);
      wait_drained();
      csr_write(pfea_pkg::CSR_GAIN_P, kp);
      csr_write(pfea_pkg::CSR_GAIN_I, ki);
      csr_write(pfea_pkg::CSR_GAIN_D, kd);
      csr_write(pfea_pkg::CSR_TIME_STEP, dt);
      csr_write(pfea_pkg::CSR_INV_STEP, inv_dt);
      csr_write(pfea_pkg::CSR_OUTPUT_LOW, lo);
      csr_write(pfea_pkg::CSR_OUTPUT_HIGH, hi);
      csr_write(pfea_pkg::CSR_SMOOTHING, sm);
      @(negedge clock);
      csr_write_enable <= 1'b0;
      setting_count++;
   endtask

   // ---------------------------------------------------------------------------------------
   // random value pickers
   // ---------------------------------------------------------------------------------------

   // extremes, zero, small values near zero and full-range words
   function automatic logic [DW-1:0] pick_word();
      case ($urandom_range(0, 6))
         0:       return pfea_pkg::SMIN;
         1:       return pfea_pkg::SMAX;
         2:       return '0;
         3, 4:    return DW'(int'($urandom_range(0, 32'h80000)) - 32'h40000);
         default: return $urandom();
      endcase
   endfunction

   // gains: mostly modest so the output is not always pinned at a limit
   function automatic logic [DW-1:0] pick_gain();
      case ($urandom_range(0, 5))
         0:       return pick_word();
         1:       return $urandom();
         default: return DW'(int'($urandom_range(0, 32'h80000)) - 32'h40000);
      endcase
   endfunction

   // time steps: unit, small, largest, zero, or a raw word that may have the unused top bit set
   function automatic logic [DW-1:0] pick_step();
      case ($urandom_range(0, 5))
         0:       return DW'(pfea_pkg::STEP_ONE);
         1, 2:    return $urandom_range(1, 32'h40000);
         3:       return 32'h7FFF_FFFF;
         4:       return '0;
         default: return $urandom();
      endcase
   endfunction

   // smoothing: zero, one, inside range, above one, or a raw word with junk above
   function automatic logic [DW-1:0] pick_smoothing();
      case ($urandom_range(0, 5))
         0:       return '0;
         1:       return 32'h0001_0000;
         2, 3:    return $urandom_range(0, 65536);
         4:       return $urandom_range(65537, 32'h1FFFF);
         default: return $urandom();
      endcase
   endfunction

   task automatic random_settings();
      logic [DW-1:0] lo;
      logic [DW-1:0] hi;
      logic [DW-1:0] a;
      logic [DW-1:0] b;
      a = pick_word();
      b = pick_word();
      case ($urandom_range(0, 4))
         0: begin
            lo = pfea_pkg::SMIN;
            hi = pfea_pkg::SMAX;
         end
         1: begin
            // ordered random pair
            lo = ($signed(a) < $signed(b)) ? a : b;
            hi = ($signed(a) < $signed(b)) ? b : a;
         end
         2: begin
            // inverted limits
            lo = ($signed(a) < $signed(b)) ? b : a;
            hi = ($signed(a) < $signed(b)) ? a : b;
         end
         default: begin
            // narrow band around zero, in whole units
            hi = $urandom_range(1, 1000) << FB;
            lo = -$signed(DW'($urandom_range(1, 1000) << FB));
         end
      endcase
      apply_settings(pick_gain(), pick_gain(), pick_gain(), pick_step(), pick_step(),
                     lo, hi, pick_smoothing());
   endtask

   // ---------------------------------------------------------------------------------------
   // response checking
   // ---------------------------------------------------------------------------------------

   // random back-pressure on the response side
   always @(negedge clock) begin
      rsp_bus.ready <= ($urandom_range(99) >= rsp_idle_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (expected_drive.size() == 0) begin
            fail_count++;
            if (fail_count <= 10) begin
               $display("response with none expected: drive %0d", rsp_bus.drive);
            end
         end else begin
            drive_want = expected_drive.pop_front();
            checked_count++;
            if (rsp_bus.drive !== drive_want) begin
               fail_count++;
               if (fail_count <= 10) begin
                  $display("drive mismatch on response %0d: expected %0d (%h) got %0d (%h)",
                           checked_count, drive_want, drive_want, rsp_bus.drive,
                           rsp_bus.drive);
               end
            end
         end
      end
   end

   // ---------------------------------------------------------------------------------------
   // tests
   // ---------------------------------------------------------------------------------------

   // reset values: zero gains and zero limits give zero drive whatever the error
   task automatic test_reset_defaults();
      send_request(pfea_pkg::MODE_UPDATE, pfea_pkg::SMAX, pfea_pkg::SMIN);
      send_request(pfea_pkg::MODE_UPDATE, pfea_pkg::SMIN, pfea_pkg::SMAX);
   endtask

   // extremes of the input fields and of the gains, with the widest limits
   task automatic test_field_extremes();
      apply_settings(32'h0001_0000, 32'h0000_8000, pfea_pkg::SMAX, DW'(pfea_pkg::STEP_ONE),
                     DW'(pfea_pkg::STEP_ONE), pfea_pkg::SMIN, pfea_pkg::SMAX, '0);
      send_request(pfea_pkg::MODE_UPDATE, pfea_pkg::SMAX, pfea_pkg::SMIN);
      send_request(pfea_pkg::MODE_UPDATE, pfea_pkg::SMIN, pfea_pkg::SMAX);
      send_request(pfea_pkg::MODE_UPDATE, '0, '0);
      send_request(pfea_pkg::MODE_UPDATE, pfea_pkg::SMAX, pfea_pkg::SMAX);
      send_request(pfea_pkg::MODE_UPDATE, pfea_pkg::SMIN, '0);
      send_request(pfea_pkg::MODE_UPDATE, '0, pfea_pkg::SMIN);
      // largest gains and steps, every intermediate pushed into saturation
      apply_settings(pfea_pkg::SMIN, pfea_pkg::SMAX, pfea_pkg::SMIN, 32'h7FFF_FFFF,
                     32'h7FFF_FFFF, pfea_pkg::SMIN, pfea_pkg::SMAX, '0);
      send_request(pfea_pkg::MODE_UPDATE, pfea_pkg::SMAX, pfea_pkg::SMIN);
      send_request(pfea_pkg::MODE_UPDATE, pfea_pkg::SMIN, pfea_pkg::SMAX);
   endtask

   // clear zeroes integral and previous error, back-to-back clears too
   task automatic test_clear_command();
      apply_settings(32'h0001_0000, 32'h0001_0000, 32'h0001_0000, DW'(pfea_pkg::STEP_ONE),
                     DW'(pfea_pkg::STEP_ONE), 32'hFC18_0000, 32'h03E8_0000, 32'h0000_8000);
      send_request(pfea_pkg::MODE_UPDATE, 32'h0001_0000, '0);
      send_request(pfea_pkg::MODE_UPDATE, 32'h0002_0000, '0);
      send_request(pfea_pkg::MODE_CLEAR, pfea_pkg::SMAX, pfea_pkg::SMIN);
      send_request(pfea_pkg::MODE_UPDATE, 32'h0001_0000, '0);
      send_request(pfea_pkg::MODE_CLEAR, '0, '0);
      send_request(pfea_pkg::MODE_CLEAR, pfea_pkg::SMIN, pfea_pkg::SMAX);
   endtask

   // smoothing of exactly one, and above one, which is taken as one
   task automatic test_smoothing_limits();
      apply_settings(32'h0001_0000, 32'h0000_4000, 32'h0000_2000, DW'(pfea_pkg::STEP_ONE),
                     DW'(pfea_pkg::STEP_ONE), pfea_pkg::SMIN, pfea_pkg::SMAX, '0);
      send_request(pfea_pkg::MODE_UPDATE, 32'h0005_0000, '0);
      apply_settings(32'h0001_0000, 32'h0000_4000, 32'h0000_2000, DW'(pfea_pkg::STEP_ONE),
                     DW'(pfea_pkg::STEP_ONE), pfea_pkg::SMIN, pfea_pkg::SMAX,
                     32'h0001_0000);
      send_request(pfea_pkg::MODE_UPDATE, pfea_pkg::SMAX, pfea_pkg::SMIN);
      apply_settings(32'h0001_0000, 32'h0000_4000, 32'h0000_2000, DW'(pfea_pkg::STEP_ONE),
                     DW'(pfea_pkg::STEP_ONE), pfea_pkg::SMIN, pfea_pkg::SMAX,
                     32'hFFFF_FFFF);
      send_request(pfea_pkg::MODE_UPDATE, pfea_pkg::SMIN, pfea_pkg::SMAX);
      send_request(pfea_pkg::MODE_UPDATE, 32'h0003_0000, 32'h0001_0000);
   endtask

   // low limit above high limit: high limit wins for large values
   task automatic test_inverted_limits();
      apply_settings(32'h0001_0000, 32'h0001_0000, '0, DW'(pfea_pkg::STEP_ONE),
                     DW'(pfea_pkg::STEP_ONE), 32'h0001_0000, 32'hFFFF_0000, 32'h0000_4000);
      send_request(pfea_pkg::MODE_UPDATE, 32'h0010_0000, '0);
      send_request(pfea_pkg::MODE_UPDATE, '0, 32'h0010_0000);
      send_request(pfea_pkg::MODE_UPDATE, '0, '0);
   endtask

   // zero time steps, written with the unused top bit set
   task automatic test_zero_steps();
      apply_settings(32'h0002_0000, 32'h0001_0000, 32'h0001_0000, 32'h8000_0000,
                     32'h8000_0000, 32'hFF00_0000, 32'h0100_0000, 32'h0000_C000);
      send_request(pfea_pkg::MODE_UPDATE, 32'h0004_0000, '0);
      send_request(pfea_pkg::MODE_UPDATE, '0, 32'h0004_0000);
      send_request(pfea_pkg::MODE_UPDATE, pfea_pkg::SMAX, pfea_pkg::SMIN);
   endtask

   // random settings per phase, mostly control updates with the odd clear
   task automatic test_random_traffic();
      logic signed [DW-1:0] tgt;
      logic signed [DW-1:0] meas;
      for (int unsigned phase = 0; phase < PHASES; phase++) begin
         random_settings();
         // one phase runs flat out on both sides
         req_idle_pct = (phase == 3) ? 0 : 15;
         rsp_idle_pct = (phase == 3) ? 0 : 15;
         for (int unsigned n = 0; n < PHASE_ITEMS; n++) begin
            // sender holds off until all responses are in
            if (n == PHASE_ITEMS / 2 && phase % 4 == 1) begin
               wait_drained();
            end
            tgt = pick_word();
            // measurement mostly tracks the setpoint, as in a closed loop
            if ($urandom_range(0, 2) != 0) begin
               meas = tgt + DW'(int'($urandom_range(0, 32'h40000)) - 32'h20000);
            end else begin
               meas = pick_word();
            end
            send_request(($urandom_range(0, 99) < 8) ? pfea_pkg::MODE_CLEAR
                                                      : pfea_pkg::MODE_UPDATE, tgt, meas);
         end
      end
      req_idle_pct = 15;
      rsp_idle_pct = 15;
   endtask

   // ---------------------------------------------------------------------------------------
   // main sequence
   // ---------------------------------------------------------------------------------------

   initial begin
      reset            = 1'b1;
      csr_write_enable = 1'b0;
      csr_index        = '0;
      csr_write_data   = '0;
      req_bus.valid    = 1'b0;
      req_bus.mode     = pfea_pkg::MODE_UPDATE;
      req_bus.target   = '0;
      req_bus.measured = '0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_reset_defaults();
      test_field_extremes();
      test_clear_command();
      test_smoothing_limits();
      test_inverted_limits();
      test_zero_steps();
      test_random_traffic();
      wait_drained();

      $display("covered %0d control updates and %0d clears over %0d register settings",
               update_count, clear_count, setting_count);
      $display("%0d responses compared, %0d failures", checked_count, fail_count);
      if (fail_count == 0 && expected_drive.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

// ----- files.f -----
rtl/pfea_pkg.sv
rtl/pfea_if.sv
rtl/pid_filtered_error_antiwindup.sv
tb/sv/tb_top.sv
